// ----- rtl/madg_pkg.sv -----
// package for the multidimensional array address generator
// holds sizes, op codes, state encoding and table layouts; no dependencies
`default_nettype none

package madg_pkg;

	// descriptor table sizes
	localparam int MAX_ARRAYS = 16;
	localparam int MAX_DIMS   = 8;
	localparam int ID_W       = $clog2(MAX_ARRAYS);
	localparam int DIM_W      = $clog2(MAX_DIMS);
	localparam int BND_DEPTH  = MAX_ARRAYS * MAX_DIMS;

	// field widths
	localparam int CNT_W   = 4;
	localparam int BASE_W  = 32;
	localparam int ESIZE_W = 8;
	localparam int IDX_W   = 16;
	localparam int ADDR_W  = 48;
	localparam int EXT_W   = IDX_W + 2;
	localparam int DIFF_W  = IDX_W + 1;

	// entry layouts: header {dim_count, element_size, base}, bounds {high, low}
	localparam int HDR_W = CNT_W + ESIZE_W + BASE_W;
	localparam int BND_W = 2 * IDX_W;

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_BOUNDS = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_BND,
		ST_SCALE,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/madg_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module madg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/multidim_array_address_gen_core.sv -----
// top level of the multidimensional array address generator
// depends on madg_pkg and madg_ram
`default_nettype none

// Row-major element address generator driven by a descriptor table. A header
// beat stores an array's base, element size and dimension count, a bounds beat
// stores one dimension's low and high bound; both leave busy low. Query beats
// carry the subscripts of one reference in dimension order and fold them as
// acc = acc * extent + (index - low). A subscript that is not the last passes
// through a header read, a bounds read and a multiply-accumulate; the last one
// adds the element-size multiply and the base add. The two memory reads are
// dependent: the bounds address needs the dimension count from the header
// entry. The address is on address for exactly one cycle with valid high and
// cannot be held off. Descriptors must be written before they are queried.
module multidim_array_address_gen_core
	import madg_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic        [1:0]         op,
	input  wire logic        [ID_W-1:0]    array_id,
	input  wire logic        [DIM_W-1:0]   dim,
	input  wire logic        [BASE_W-1:0]  base,
	input  wire logic        [ESIZE_W-1:0] element_size,
	input  wire logic        [CNT_W-1:0]   dim_count,
	input  wire logic signed [IDX_W-1:0]   low_bound,
	input  wire logic signed [IDX_W-1:0]   high_bound,
	input  wire logic signed [IDX_W-1:0]   index,
	output logic                           valid,
	output logic             [ID_W-1:0]    array_id_res,
	output logic signed      [ADDR_W-1:0]  address
);

	state_t state_q, state_d;

	logic                 accept;
	op_t                  op_in;
	logic                 hdr_we, bnd_we, hdr_re, bnd_re;
	logic [HDR_W-1:0]     hdr_rdata;
	logic [BND_W-1:0]     bnd_rdata;
	logic [ID_W+DIM_W-1:0] bnd_waddr, bnd_raddr;

	// query context
	logic [ID_W-1:0]      id_q;
	logic [IDX_W-1:0]     idx_q;
	logic [BASE_W-1:0]    base_q;
	logic [ESIZE_W-1:0]   esize_q;
	logic [DIM_W-1:0]     pos_q;
	logic                 last_q;
	logic [ADDR_W-1:0]    acc_q;
	logic [DIM_W-1:0]     cnt_q;
	logic [ADDR_W-1:0]    prod_q;

	// header decode
	logic [CNT_W-1:0]     hdr_cnt, eff;
	logic [DIM_W-1:0]     pos;
	logic                 last;

	// datapath
	logic [IDX_W-1:0]     lo, hi;
	logic signed [EXT_W-1:0]  extent;
	logic signed [DIFF_W-1:0] diff;
	logic signed [ADDR_W+EXT_W:0] mac_mul;
	logic [ADDR_W-1:0]    acc_new;
	logic [ADDR_W+ESIZE_W-1:0] scaled;

	logic                 valid_q;
	logic [ID_W-1:0]      id_res_q;
	logic [ADDR_W-1:0]    addr_q;

	assign op_in  = op_t'(op);
	assign accept = start && !busy;

	// descriptor writes and the header read of a query subscript
	assign hdr_we    = accept && op_in == OP_HEADER && 32'(array_id) < MAX_ARRAYS;
	assign bnd_we    = accept && op_in == OP_BOUNDS && 32'(array_id) < MAX_ARRAYS
		&& 32'(dim) < MAX_DIMS;
	assign hdr_re    = accept && op_in == OP_QUERY;
	assign bnd_waddr = {array_id, dim};

	madg_ram #(.WIDTH(HDR_W), .DEPTH(MAX_ARRAYS)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (array_id),
		.wdata ({dim_count, element_size, base}),
		.re    (hdr_re),
		.raddr (array_id),
		.rdata (hdr_rdata)
	);

	// effective dimension count and position within the reference
	assign hdr_cnt = hdr_rdata[HDR_W-1 -: CNT_W];
	always_comb begin
		if (hdr_cnt == '0) begin
			eff = CNT_W'(1);
		end else if (32'(hdr_cnt) > MAX_DIMS) begin
			eff = CNT_W'(MAX_DIMS);
		end else begin
			eff = hdr_cnt;
		end
		if (CNT_W'(cnt_q) >= eff) begin
			pos = DIM_W'(eff - CNT_W'(1));
		end else begin
			pos = cnt_q;
		end
		last = (CNT_W'(pos) + CNT_W'(1)) >= eff;
	end

	assign bnd_re    = state_q == ST_HDR;
	assign bnd_raddr = {id_q, pos};

	madg_ram #(.WIDTH(BND_W), .DEPTH(BND_DEPTH)) u_bnd_ram (
		.clk   (clk),
		.we    (bnd_we),
		.waddr (bnd_waddr),
		.wdata ({high_bound, low_bound}),
		.re    (bnd_re),
		.raddr (bnd_raddr),
		.rdata (bnd_rdata)
	);

	// extent, subscript offset and multiply-accumulate
	assign lo      = bnd_rdata[IDX_W-1:0];
	assign hi      = bnd_rdata[BND_W-1:IDX_W];
	assign extent  = $signed({{2{hi[IDX_W-1]}}, hi}) - $signed({{2{lo[IDX_W-1]}}, lo})
		+ $signed(EXT_W'(1));
	assign diff    = $signed({idx_q[IDX_W-1], idx_q}) - $signed({lo[IDX_W-1], lo});
	assign mac_mul = $signed({1'b0, acc_q}) * extent;
	assign acc_new = mac_mul[ADDR_W-1:0]
		+ {{(ADDR_W-DIFF_W){diff[DIFF_W-1]}}, diff};

	// element-size scaling
	assign scaled = acc_q * esize_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (hdr_re) begin
					state_d = ST_HDR;
				end
			end
			ST_HDR:   state_d = ST_BND;
			ST_BND:   state_d = last_q ? ST_SCALE : ST_IDLE;
			ST_SCALE: state_d = ST_EMIT;
			ST_EMIT:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// accumulator and dimension counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (state_q == ST_BND) begin
				acc_q <= acc_new;
				cnt_q <= last_q ? '0 : pos_q + DIM_W'(1);
			end else if (state_q == ST_SCALE) begin
				acc_q <= '0;
			end
		end
	end

	// query context and product registers
	always_ff @(posedge clk) begin
		if (hdr_re) begin
			id_q  <= array_id;
			idx_q <= index;
		end
		if (state_q == ST_HDR) begin
			base_q  <= hdr_rdata[BASE_W-1:0];
			esize_q <= hdr_rdata[BASE_W +: ESIZE_W];
			pos_q   <= pos;
			last_q  <= last;
		end
		if (state_q == ST_SCALE) begin
			prod_q <= scaled[ADDR_W-1:0];
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= state_q == ST_EMIT;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			id_res_q <= id_q;
			addr_q   <= {{(ADDR_W-BASE_W){1'b0}}, base_q} + prod_q;
		end
	end

	assign valid        = valid_q;
	assign array_id_res = id_res_q;
	assign address      = $signed(addr_q);

	// a result beat only follows the address add
	a_valid_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q == ST_EMIT))
		else $error("result beat without address add");

	// a query subscript always starts with the header read
	a_query_reads_header: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_QUERY) |=> state_q == ST_HDR)
		else $error("query subscript did not start header read");

	// the reference context is cleared once the final subscript is folded
	a_ctx_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE |=> acc_q == '0 && cnt_q == '0)
		else $error("accumulator or counter not cleared after last subscript");

	// the counter only moves while a subscript is folded
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !(start && op == OP_QUERY)) |=> $stable(cnt_q))
		else $error("dimension counter moved while idle");

endmodule

`default_nettype wire
